// ===== hw/rtl/cdov_pkg.sv =====
// Shared types and constants of the complex-domain onset value block.
`default_nettype none

package cdov_pkg;

    // Sequencer states
    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DEV,
        S_MUL,
        S_ACC,
        S_END,
        S_DIV,
        S_CMP,
        S_NEG,
        S_SCALE,
        S_UPD,
        S_OUT
    } t_state;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BIN = 2'd2;

    localparam int unsigned MINB_W = 6;
    localparam int unsigned MAXB_W = 7;
    localparam int unsigned CFG_DATA_W = 7;

    // Analysis range used when min_bin is not below max_bin
    localparam int unsigned FALLBACK_LO = 1;
    localparam int unsigned FALLBACK_HI = 64;

    // Averaging weight, Q0.16 (about 0.05)
    localparam int unsigned ALPHA_W = 12;
    localparam int unsigned ALPHA_IDX_W = 4;
    localparam logic [ALPHA_W-1:0] ALPHA_Q16 = 12'd3277;

    localparam int unsigned FRAC_W = 16;
    localparam int unsigned OUT_W  = 31;
    localparam int unsigned EXT_W  = 64;

    localparam logic [1:0] WARM_FRAMES = 2'd2;

endpackage : cdov_pkg

`default_nettype wire

// ===== hw/rtl/cdov_hist.sv =====
// Phase history memory: one entry per bin holding the last two phases.
`default_nettype none

module cdov_hist #(
    parameter int unsigned DEPTH  = 64,
    parameter int unsigned DATA_W = 32,
    parameter int unsigned ADDR_W = 6
) (
    input  wire logic              i_clk,
    input  wire logic              i_wr_en,
    input  wire logic [ADDR_W-1:0] i_wr_addr,
    input  wire logic [DATA_W-1:0] i_wr_data,
    input  wire logic [ADDR_W-1:0] i_rd_addr,
    output logic      [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule : cdov_hist

`default_nettype wire

// ===== hw/rtl/cdov_dev.sv =====
// Absolute wrapped deviation of a phase from its linear extrapolation.
`default_nettype none

module cdov_dev #(
    parameter int unsigned PHASE_BITS = 16
) (
    input  wire logic [PHASE_BITS-1:0] i_now,
    input  wire logic [PHASE_BITS-1:0] i_prev,
    input  wire logic [PHASE_BITS-1:0] i_older,
    output logic      [PHASE_BITS-1:0] o_dev
);

    logic [PHASE_BITS-1:0] w_diff;

    // Wraps modulo one turn; the top bit set means half a turn or more
    assign w_diff = i_now - i_prev - i_prev + i_older;
    assign o_dev  = w_diff[PHASE_BITS-1] ? (~w_diff + PHASE_BITS'(1)) : w_diff;

endmodule : cdov_dev

`default_nettype wire

// ===== hw/rtl/cdov_alu.sv =====
// Shared add/subtract unit with carry out.
`default_nettype none

module cdov_alu #(
    parameter int unsigned ALU_W = 59
) (
    input  wire logic [ALU_W-1:0] i_a,
    input  wire logic [ALU_W-1:0] i_b,
    input  wire logic             i_sub,
    output logic      [ALU_W-1:0] o_res,
    output logic                  o_carry
);

    logic [ALU_W:0] w_sum;

    // Subtract as a plus the inverse of b plus one; carry high means no borrow
    assign w_sum = {1'b0, i_a} + {1'b0, (i_sub ? ~i_b : i_b)} + (ALU_W + 1)'(i_sub);
    assign o_res   = w_sum[ALU_W-1:0];
    assign o_carry = w_sum[ALU_W];

endmodule : cdov_alu

`default_nettype wire

// ===== hw/rtl/complex_domain_onset_value.sv =====
// Complex-domain onset value: top level with sequencer and shared arithmetic.
// Each bin takes one history read and, if analysed, one shared-adder pass; a closing bin adds
// a bit-serial division and a 12-step average, its result waiting for the output register to be free.
// A new bin is taken only once the last one is done. Reset (synchronous, active low) clears control
// state, then zeroes the history one bin per cycle; no input is taken meanwhile.
`default_nettype none

module complex_domain_onset_value #(
    parameter int unsigned BIN_COUNT  = 64,
    parameter int unsigned PHASE_BITS = 16,
    parameter int unsigned MAG_BITS   = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write port
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [cdov_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [cdov_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // bin input channel
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [MAG_BITS-1:0]            i_magnitude,
    input  wire logic signed [PHASE_BITS-1:0]   i_phase,
    input  wire logic                           i_last_bin,
    input  wire logic                           i_spectrum_valid,
    // result channel
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [cdov_pkg::OUT_W-1:0]          o_onset_value,
    output logic [cdov_pkg::OUT_W-1:0]          o_running_average,
    output logic                                o_ready_res
);

    import cdov_pkg::*;

    localparam int unsigned BIN_W  = $clog2(BIN_COUNT);
    localparam int unsigned POS_W  = $clog2(BIN_COUNT + 1);
    localparam int unsigned CNT_W  = POS_W;
    localparam int unsigned ONS_W  = MAG_BITS + PHASE_BITS - 1;
    localparam int unsigned SUM_W  = ONS_W + CNT_W;
    localparam int unsigned AVG_W  = ONS_W + FRAC_W;
    localparam int unsigned ALU_W  = AVG_W + ALPHA_W;
    localparam int unsigned ITER_W = $clog2(SUM_W);
    localparam int unsigned CMP_W  = (POS_W > MAXB_W) ? POS_W : MAXB_W;
    localparam int unsigned HIST_W = 2 * PHASE_BITS;
    localparam int unsigned RST_MAX = (FALLBACK_HI > BIN_COUNT) ? BIN_COUNT : FALLBACK_HI;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic              r_enable;
    logic [MINB_W-1:0] r_min_bin;
    logic [MAXB_W-1:0] r_max_bin;
    logic [MAXB_W-1:0] w_cfg_max;

    // Clamp max_bin to the store depth as it is written
    assign w_cfg_max = (CMP_W'(i_cfg_wdata[MAXB_W-1:0]) > CMP_W'(BIN_COUNT))
                     ? MAXB_W'(BIN_COUNT) : i_cfg_wdata[MAXB_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable  <= 1'b1;
            r_min_bin <= MINB_W'(FALLBACK_LO);
            r_max_bin <= MAXB_W'(RST_MAX);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_ENABLE:  r_enable  <= i_cfg_wdata[0];
                CFG_MIN_BIN: r_min_bin <= i_cfg_wdata[MINB_W-1:0];
                CFG_MAX_BIN: r_max_bin <= w_cfg_max;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    t_state r_state, n_state;

    // control, cleared by reset
    logic [BIN_W-1:0]  r_clr_addr, n_clr_addr;
    logic [POS_W-1:0]  r_pos,      n_pos;
    logic [1:0]        r_frames,   n_frames;
    logic [SUM_W-1:0]  r_sum,      n_sum;
    logic [CNT_W-1:0]  r_cnt,      n_cnt;
    logic [AVG_W-1:0]  r_avg,      n_avg;
    logic [ITER_W-1:0] r_iter,     n_iter;
    logic              r_o_valid,  n_o_valid;

    // datapath, no reset
    logic [MAG_BITS-1:0]   r_mag,   n_mag;
    logic [PHASE_BITS-1:0] r_ph,    n_ph;
    logic                  r_last,  n_last;
    logic                  r_hit,   n_hit;
    logic                  r_inmem, n_inmem;
    logic [PHASE_BITS-1:0] r_dev,   n_dev;
    logic [ONS_W-1:0]      r_prod,  n_prod;
    logic [CNT_W:0]        r_rem,   n_rem;
    logic [AVG_W-1:0]      r_diff,  n_diff;
    logic                  r_up,    n_up;
    logic [ALU_W-1:0]      r_acc,   n_acc;
    logic [ONS_W-1:0]      r_onset, n_onset;
    logic                  r_res,   n_res;
    logic [OUT_W-1:0]      r_o_onset, n_o_onset;
    logic [OUT_W-1:0]      r_o_avg,   n_o_avg;
    logic                  r_o_res,   n_o_res;

    // ---------------------------------------------------------------
    // History memory and deviation
    // ---------------------------------------------------------------
    logic                  w_mem_we;
    logic [BIN_W-1:0]      w_mem_waddr;
    logic [HIST_W-1:0]     w_mem_wdata;
    logic [HIST_W-1:0]     w_mem_rdata;
    logic [PHASE_BITS-1:0] w_prev, w_older, w_dev;

    // Read address follows the bin position, so the entry is ready the
    // cycle after a transaction is accepted.
    cdov_hist #(
        .DEPTH  (BIN_COUNT),
        .DATA_W (HIST_W),
        .ADDR_W (BIN_W)
    ) u_hist (
        .i_clk     (i_clk),
        .i_wr_en   (w_mem_we),
        .i_wr_addr (w_mem_waddr),
        .i_wr_data (w_mem_wdata),
        .i_rd_addr (r_pos[BIN_W-1:0]),
        .o_rd_data (w_mem_rdata)
    );

    assign w_prev  = w_mem_rdata[HIST_W-1:PHASE_BITS];
    assign w_older = w_mem_rdata[PHASE_BITS-1:0];

    cdov_dev #(
        .PHASE_BITS (PHASE_BITS)
    ) u_dev (
        .i_now   (r_ph),
        .i_prev  (w_prev),
        .i_older (w_older),
        .o_dev   (w_dev)
    );

    // ---------------------------------------------------------------
    // Shared adder
    // ---------------------------------------------------------------
    logic [ALU_W-1:0] w_alu_a, w_alu_b, w_alu_res;
    logic             w_alu_sub, w_alu_carry;

    cdov_alu #(
        .ALU_W (ALU_W)
    ) u_alu (
        .i_a     (w_alu_a),
        .i_b     (w_alu_b),
        .i_sub   (w_alu_sub),
        .o_res   (w_alu_res),
        .o_carry (w_alu_carry)
    );

    // ---------------------------------------------------------------
    // Helpers
    // ---------------------------------------------------------------
    logic [CMP_W-1:0]                   w_lo, w_hi, w_pos_ext;
    logic                               w_in_store, w_in_range;
    logic [AVG_W-1:0]                   w_target;
    logic [CNT_W:0]                     w_rem_sh;
    logic                               w_borrow;
    logic [SUM_W-1:0]                   w_quo_next;
    logic [MAG_BITS+PHASE_BITS-1:0]     w_prod_full;
    logic [EXT_W-1:0]                   w_onset_ext, w_avg_ext;

    // Fall back to the default range when min_bin is not below max_bin
    always_comb begin
        if (CMP_W'(r_min_bin) >= CMP_W'(r_max_bin)) begin
            w_lo = CMP_W'(FALLBACK_LO);
            w_hi = CMP_W'(FALLBACK_HI);
        end else begin
            w_lo = CMP_W'(r_min_bin);
            w_hi = CMP_W'(r_max_bin);
        end
    end

    assign w_pos_ext  = CMP_W'(r_pos);
    assign w_in_store = (r_pos < POS_W'(BIN_COUNT));
    assign w_in_range = (w_pos_ext >= w_lo) && (w_pos_ext < w_hi);

    assign w_target    = {r_onset, FRAC_W'(0)};
    assign w_rem_sh    = {r_rem[CNT_W-1:0], r_sum[SUM_W-1]};
    assign w_borrow    = !w_alu_carry;
    assign w_quo_next  = {r_sum[SUM_W-2:0], !w_borrow};
    assign w_prod_full = r_mag * r_dev;
    assign w_onset_ext = EXT_W'(r_onset);
    assign w_avg_ext   = EXT_W'(r_avg);

    // Adder operands per step
    always_comb begin
        w_alu_a   = '0;
        w_alu_b   = '0;
        w_alu_sub = 1'b0;
        unique case (r_state)
            S_ACC: begin
                w_alu_a = ALU_W'(r_sum);
                w_alu_b = ALU_W'(r_prod);
            end
            S_DIV: begin
                w_alu_a   = ALU_W'(w_rem_sh);
                w_alu_b   = ALU_W'(r_cnt);
                w_alu_sub = 1'b1;
            end
            S_CMP: begin
                w_alu_a   = ALU_W'(w_target);
                w_alu_b   = ALU_W'(r_avg);
                w_alu_sub = 1'b1;
            end
            S_NEG: begin
                w_alu_a   = ALU_W'(r_avg);
                w_alu_b   = ALU_W'(w_target);
                w_alu_sub = 1'b1;
            end
            S_SCALE: begin
                // shift-and-add over the weight, most significant bit first
                w_alu_a = {r_acc[ALU_W-2:0], 1'b0};
                w_alu_b = ALPHA_Q16[r_iter[ALPHA_IDX_W-1:0]] ? ALU_W'(r_diff) : '0;
            end
            S_UPD: begin
                w_alu_a   = ALU_W'(r_avg);
                w_alu_b   = ALU_W'(r_acc[ALU_W-1:FRAC_W]);
                w_alu_sub = !r_up;
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_pos      = r_pos;
        n_frames   = r_frames;
        n_sum      = r_sum;
        n_cnt      = r_cnt;
        n_avg      = r_avg;
        n_iter     = r_iter;
        n_o_valid  = r_o_valid;
        n_mag      = r_mag;
        n_ph       = r_ph;
        n_last     = r_last;
        n_hit      = r_hit;
        n_inmem    = r_inmem;
        n_dev      = r_dev;
        n_prod     = r_prod;
        n_rem      = r_rem;
        n_diff     = r_diff;
        n_up       = r_up;
        n_acc      = r_acc;
        n_onset    = r_onset;
        n_res      = r_res;
        n_o_onset  = r_o_onset;
        n_o_avg    = r_o_avg;
        n_o_res    = r_o_res;
        w_mem_we    = 1'b0;
        w_mem_waddr = r_pos[BIN_W-1:0];
        w_mem_wdata = {r_ph, w_prev};

        // Drop the result once the consumer takes it
        if (r_o_valid && i_ready) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                w_mem_we    = 1'b1;
                w_mem_waddr = r_clr_addr;
                w_mem_wdata = '0;
                if (r_clr_addr == BIN_W'(BIN_COUNT - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + BIN_W'(1);
                end
            end
            S_IDLE: begin
                // Disabled or empty-spectrum transactions are taken and dropped
                if (i_valid && r_enable && i_spectrum_valid) begin
                    n_mag   = i_magnitude;
                    n_ph    = $unsigned(i_phase);
                    n_last  = i_last_bin;
                    n_inmem = w_in_store;
                    n_hit   = w_in_store && w_in_range && (r_frames == WARM_FRAMES);
                    n_state = S_DEV;
                end
            end
            S_DEV: begin
                n_dev = w_dev;
                if (r_inmem) begin
                    // Age the history and advance the bin position
                    w_mem_we = 1'b1;
                    n_pos    = r_pos + POS_W'(1);
                end
                n_state = r_hit ? S_MUL : S_END;
            end
            S_MUL: begin
                n_prod  = w_prod_full[ONS_W-1:0];
                n_state = S_ACC;
            end
            S_ACC: begin
                n_sum   = w_alu_res[SUM_W-1:0];
                n_cnt   = r_cnt + CNT_W'(1);
                n_state = S_END;
            end
            S_END: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else begin
                    n_pos = '0;
                    if (r_frames != WARM_FRAMES) begin
                        // Warm-up frame: history only, zero result
                        n_frames = r_frames + 2'd1;
                        n_onset  = '0;
                        n_res    = 1'b0;
                        n_state  = S_OUT;
                    end else if (r_cnt == '0) begin
                        n_onset = '0;
                        n_res   = 1'b1;
                        n_state = S_CMP;
                    end else begin
                        n_rem   = '0;
                        n_iter  = ITER_W'(SUM_W - 1);
                        n_res   = 1'b1;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                // Restoring division, one quotient bit per cycle
                n_rem = w_borrow ? w_rem_sh : w_alu_res[CNT_W:0];
                n_sum = w_quo_next;
                if (r_iter == '0) begin
                    n_onset = w_quo_next[ONS_W-1:0];
                    n_state = S_CMP;
                end else begin
                    n_iter = r_iter - ITER_W'(1);
                end
            end
            S_CMP: begin
                if (w_alu_carry) begin
                    n_diff  = w_alu_res[AVG_W-1:0];
                    n_up    = 1'b1;
                    n_acc   = '0;
                    n_iter  = ITER_W'(ALPHA_W - 1);
                    n_state = S_SCALE;
                end else begin
                    n_state = S_NEG;
                end
            end
            S_NEG: begin
                n_diff  = w_alu_res[AVG_W-1:0];
                n_up    = 1'b0;
                n_acc   = '0;
                n_iter  = ITER_W'(ALPHA_W - 1);
                n_state = S_SCALE;
            end
            S_SCALE: begin
                n_acc = w_alu_res;
                if (r_iter == '0) begin
                    n_state = S_UPD;
                end else begin
                    n_iter = r_iter - ITER_W'(1);
                end
            end
            S_UPD: begin
                n_avg   = w_alu_res[AVG_W-1:0];
                n_state = S_OUT;
            end
            S_OUT: begin
                // Hold until the output register is free
                if (!r_o_valid || i_ready) begin
                    n_o_valid = 1'b1;
                    n_o_onset = w_onset_ext[OUT_W-1:0];
                    n_o_avg   = r_res ? w_avg_ext[FRAC_W +: OUT_W] : '0;
                    n_o_res   = r_res;
                    n_sum     = '0;
                    n_cnt     = '0;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_pos      <= '0;
            r_frames   <= '0;
            r_sum      <= '0;
            r_cnt      <= '0;
            r_avg      <= '0;
            r_iter     <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_pos      <= n_pos;
            r_frames   <= n_frames;
            r_sum      <= n_sum;
            r_cnt      <= n_cnt;
            r_avg      <= n_avg;
            r_iter     <= n_iter;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag     <= n_mag;
        r_ph      <= n_ph;
        r_last    <= n_last;
        r_hit     <= n_hit;
        r_inmem   <= n_inmem;
        r_dev     <= n_dev;
        r_prod    <= n_prod;
        r_rem     <= n_rem;
        r_diff    <= n_diff;
        r_up      <= n_up;
        r_acc     <= n_acc;
        r_onset   <= n_onset;
        r_res     <= n_res;
        r_o_onset <= n_o_onset;
        r_o_avg   <= n_o_avg;
        r_o_res   <= n_o_res;
    end

    assign o_ready           = (r_state == S_IDLE);
    assign o_valid           = r_o_valid;
    assign o_onset_value     = r_o_onset;
    assign o_running_average = r_o_avg;
    assign o_ready_res       = r_o_res;

endmodule : complex_domain_onset_value

`default_nettype wire

// ===== tb/sv/complex_domain_onset_value_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the complex-domain onset value block.

module complex_domain_onset_value_test;
    import cdov_pkg::*;

    localparam int BIN_COUNT   = 64;
    localparam int PH_W        = 16;
    localparam int MAG_W       = 16;
    localparam int SETTLE      = 80;      // margin for a closing bin to finish
    localparam int HOLD_CYCLES = 600;     // long receiver hold-off
    localparam int SEG_BINS    = 150;     // counted bins per configuration segment
    localparam int NUM_SEGS    = 8;
    localparam int LIMIT       = 500000;  // cycles before the run is declared hung

    // Index with no register behind it: a write must leave everything alone
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic [PH_W-1:0]  ph;
        logic             last;
        logic             spec;
    } bin_txn_t;

    typedef struct packed {
        logic [OUT_W-1:0] onset;
        logic [OUT_W-1:0] average;
        logic             warm_done;
    } onset_result_t;

    // DUT inputs, all known from time zero
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [MAG_W-1:0]      i_magnitude = '0;
    logic signed [PH_W-1:0] i_phase = '0;
    logic                  i_last_bin = 1'b0;
    logic                  i_spectrum_valid = 1'b0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [OUT_W-1:0]      o_onset_value;
    logic [OUT_W-1:0]      o_running_average;
    logic                  o_ready_res;

    complex_domain_onset_value dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_magnitude       (i_magnitude),
        .i_phase           (i_phase),
        .i_last_bin        (i_last_bin),
        .i_spectrum_valid  (i_spectrum_valid),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_onset_value     (o_onset_value),
        .o_running_average (o_running_average),
        .o_ready_res       (o_ready_res)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    bin_txn_t      bin_q[$];           // bins waiting to be offered
    onset_result_t onset_expect_q[$];  // frame results still owed by the block
    int            tx_idle_pct = 0;
    int            rx_idle_pct = 0;
    logic          rx_hold = 1'b0;
    logic          hold_go = 1'b0;
    int            errors = 0;
    int            cycle_cnt = 0;

    // Predictor state: its own copy of the registers and the phase history
    logic          cfg_en;
    logic [5:0]    cfg_lo;
    logic [6:0]    cfg_hi;
    logic [PH_W-1:0] hist_prev [BIN_COUNT];
    logic [PH_W-1:0] hist_older[BIN_COUNT];
    int unsigned   frames_done;
    int unsigned   bin_idx;
    int unsigned   bins_used;
    logic [63:0]   dev_sum;
    logic [63:0]   avg_q16;

    // Stimulus shadow of the history, used to aim phases near the prediction
    logic [PH_W-1:0] gen_prev [BIN_COUNT];
    logic [PH_W-1:0] gen_older[BIN_COUNT];
    int            gen_pos;
    int            queued_bins;

    // Absolute phase deviation from the linear extrapolation, wrapped to one turn.
    // A deviation of exactly half a turn stays positive (2^(PH_W-1)).
    function automatic logic [PH_W:0] phase_error(logic [PH_W-1:0] now,
                                                  logic [PH_W-1:0] prev,
                                                  logic [PH_W-1:0] older);
        logic [PH_W-1:0] d;
        d = now - prev - prev + older;
        if (d[PH_W-1])
            return (PH_W + 1)'(1 << PH_W) - {1'b0, d};
        return {1'b0, d};
    endfunction

    // Advance the predictor by one accepted bin transaction; queue a result on frame end.
    task automatic track_bin(bin_txn_t t);
        int unsigned   lo;
        int unsigned   hi;
        logic [63:0]   onset;
        logic [63:0]   target;
        onset_result_t r;
        if (!cfg_en || !t.spec)
            return;
        lo = 32'(cfg_lo);
        hi = 32'(cfg_hi);
        if (lo >= hi) begin
            lo = FALLBACK_LO;
            hi = FALLBACK_HI;
        end
        // bins past the history store neither count nor touch the history
        if (bin_idx < BIN_COUNT) begin
            if (frames_done >= WARM_FRAMES && bin_idx >= lo && bin_idx < hi) begin
                dev_sum += 64'(t.mag) *
                           64'(phase_error(t.ph, hist_prev[bin_idx], hist_older[bin_idx]));
                bins_used++;
            end
            hist_older[bin_idx] = hist_prev[bin_idx];
            hist_prev[bin_idx]  = t.ph;
            bin_idx++;
        end
        if (!t.last)
            return;
        bin_idx = 0;
        r = '0;
        if (frames_done < WARM_FRAMES) begin
            // warm-up frame: history only, all-zero result
            frames_done++;
        end else begin
            onset = (bins_used != 0) ? dev_sum / 64'(bins_used) : 64'd0;
            // move the average one alpha step toward the new value, truncating the step
            target = onset << FRAC_W;
            if (target >= avg_q16)
                avg_q16 += ((target - avg_q16) * 64'(ALPHA_Q16)) >> FRAC_W;
            else
                avg_q16 -= ((avg_q16 - target) * 64'(ALPHA_Q16)) >> FRAC_W;
            r.onset     = onset[OUT_W-1:0];
            r.average   = avg_q16[FRAC_W +: OUT_W];
            r.warm_done = 1'b1;
        end
        dev_sum   = '0;
        bins_used = 0;
        onset_expect_q.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Configuration mirror: follow every register write at the edge it lands
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_ENABLE:  cfg_en = i_cfg_wdata[0];
                CFG_MIN_BIN: cfg_lo = i_cfg_wdata[MINB_W-1:0];
                CFG_MAX_BIN: cfg_hi = (i_cfg_wdata > BIN_COUNT) ? 7'(BIN_COUNT)
                                                                : i_cfg_wdata[MAXB_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Bin driver: offer queued transactions, hold valid and payload until taken
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : bin_driver
        bin_txn_t nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready)
                track_bin('{i_magnitude, i_phase, i_last_bin, i_spectrum_valid});
            // only move on once the current transaction has gone
            if (!i_valid || o_ready) begin
                if (bin_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    nxt = bin_q.pop_front();
                    i_valid          <= 1'b1;
                    i_magnitude      <= nxt.mag;
                    i_phase          <= nxt.ph;
                    i_last_bin       <= nxt.last;
                    i_spectrum_valid <= nxt.spec;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random back-pressure, plus the long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_ready <= 1'b0;
        else
            i_ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // ------------------------------------------------------------------
    // Result monitor: compare each result transaction with the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        onset_result_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (onset_expect_q.size() == 0) begin
                errors++;
                $display("%0t unexpected result: onset_value %0d running_average %0d ready_res %0b",
                         $time, o_onset_value, o_running_average, o_ready_res);
            end else begin
                want = onset_expect_q.pop_front();
                if (o_onset_value !== want.onset) begin
                    errors++;
                    $display("%0t onset_value mismatch: expected %0d, got %0d",
                             $time, want.onset, o_onset_value);
                end
                if (o_running_average !== want.average) begin
                    errors++;
                    $display("%0t running_average mismatch: expected %0d, got %0d",
                             $time, want.average, o_running_average);
                end
                if (o_ready_res !== want.warm_done) begin
                    errors++;
                    $display("%0t ready_res mismatch: expected %0b, got %0b",
                             $time, want.warm_done, o_ready_res);
                end
            end
        end
    end

    // Watchdog: give up on a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, onset_expect_q.size());
            $display("status: fail");
            $finish;
        end
    end

    // Long receiver hold-off, counted here: the block must fill and stall its input
    initial begin : receiver_hold
        wait (hold_go);
        repeat (20) @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_bin(logic [MAG_W-1:0] mag, logic [PH_W-1:0] ph,
                            logic last, logic spec);
        bin_txn_t t;
        t = '{mag, ph, last, spec};
        bin_q.push_back(t);
        if (spec) begin
            queued_bins++;
            if (gen_pos < BIN_COUNT) begin
                gen_older[gen_pos] = gen_prev[gen_pos];
                gen_prev[gen_pos]  = ph;
                gen_pos++;
            end
            if (last)
                gen_pos = 0;
        end
    endtask

    // Queue one frame: mostly short, some full, a few running past the store.
    // Phases are random, near the extrapolation, near half a turn off it, or extremes.
    task automatic queue_frame();
        int              n_bins;
        int              style;
        int              pick;
        logic [MAG_W-1:0] mag;
        logic [PH_W-1:0]  ph;
        logic [PH_W-1:0]  guess;
        pick = $urandom_range(99);
        if (pick < 60)
            n_bins = $urandom_range(16, 1);
        else if (pick < 90)
            n_bins = $urandom_range(64, 17);
        else
            n_bins = $urandom_range(80, 65);
        style = $urandom_range(3);
        for (int b = 0; b < n_bins; b++) begin
            // stray transaction with no spectral data; its last_bin must not close the frame
            if ($urandom_range(99) < 5)
                push_bin(MAG_W'($urandom), PH_W'($urandom), 1'($urandom_range(1)), 1'b0);
            if (gen_pos < BIN_COUNT)
                guess = PH_W'(2 * gen_prev[gen_pos] - gen_older[gen_pos]);
            else
                guess = PH_W'($urandom);
            case (style)
                0: ph = PH_W'($urandom);
                1: ph = guess + PH_W'($urandom_range(128) - 64);
                2: ph = guess + 16'h8000 + PH_W'($urandom_range(4)) - 16'd2;
                default: begin
                    case ($urandom_range(3))
                        0: ph = 16'h7FFF;
                        1: ph = 16'h8000;
                        2: ph = 16'h0000;
                        default: ph = PH_W'($urandom);
                    endcase
                end
            endcase
            case ($urandom_range(7))
                0: mag = '1;
                1: mag = '0;
                2: mag = MAG_W'($urandom_range(255));
                default: mag = MAG_W'($urandom);
            endcase
            push_bin(mag, ph, b == n_bins - 1, 1'b1);
        end
    endtask

    // Wait until every bin is taken and every result has arrived, then let the
    // block finish any frame close that produced nothing visible yet.
    task automatic wait_drained();
        while (bin_q.size() != 0 || i_valid || onset_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [5:0] lo;
        logic [6:0] hi;
        // predictor and shadow start from the reset state
        cfg_en      = 1'b1;
        cfg_lo      = 6'd1;
        cfg_hi      = 7'd64;
        frames_done = 0;
        bin_idx     = 0;
        bins_used   = 0;
        dev_sum     = '0;
        avg_q16     = '0;
        gen_pos     = 0;
        queued_bins = 0;
        for (int b = 0; b < BIN_COUNT; b++) begin
            hist_prev[b]  = '0;
            hist_older[b] = '0;
            gen_prev[b]   = '0;
            gen_older[b]  = '0;
        end

        repeat (3) @(posedge i_clk);
        i_rst_n     <= 1'b1;
        tx_idle_pct <= 24;
        rx_idle_pct <= 73;

        // Two warm-up frames: history only, zero results
        push_bin(16'd100,   16'h0000, 1'b0, 1'b1);
        push_bin(16'd200,   16'h0000, 1'b1, 1'b1);
        push_bin(16'h0000,  16'h0000, 1'b0, 1'b1);
        push_bin(16'hFFFF,  16'h0000, 1'b1, 1'b1);
        // Full magnitude at exactly half a turn off: largest onset value
        push_bin(16'hFFFF,  16'h7FFF, 1'b0, 1'b1);
        push_bin(16'hFFFF,  16'h8000, 1'b1, 1'b1);
        // Stray item with last_bin set mid-frame, zero magnitude, bin never written before
        push_bin(16'd1,     16'h0000, 1'b0, 1'b1);
        push_bin(16'hFFFF,  16'h3039, 1'b1, 1'b0);
        push_bin(16'h0000,  16'h7FFF, 1'b0, 1'b1);
        push_bin(16'hFFFF,  16'hFFFF, 1'b1, 1'b1);
        // Frame with no analysed bin: onset zero, average decays
        push_bin(16'd500,   16'h03E8, 1'b1, 1'b1);
        // Phase extremes back to back
        push_bin(16'd7,     16'h8000, 1'b0, 1'b1);
        push_bin(16'hFFFF,  16'h7FFF, 1'b0, 1'b1);
        push_bin(16'd1234,  16'h8000, 1'b1, 1'b1);
        wait_drained();

        // Block disabled: everything ignored, frame position untouched
        write_reg(CFG_ENABLE, '0);
        push_bin(16'hFFFF, 16'h1234, 1'b0, 1'b1);
        push_bin(16'h0001, 16'h8000, 1'b1, 1'b1);
        push_bin(16'h8000, 16'h7FFF, 1'b1, 1'b0);
        push_bin(16'h00FF, 16'h0001, 1'b1, 1'b1);
        wait_drained();
        write_reg(CFG_ENABLE, CFG_DATA_W'(1));

        // Random segments, each under its own analysis range
        for (int seg = 0; seg < NUM_SEGS; seg++) begin
            wait_drained();
            case (seg)
                0: begin lo = 6'd0;  hi = 7'd64;  end
                1: begin lo = 6'd63; hi = 7'd64;  end
                2: begin lo = 6'd63; hi = 7'd1;   end  // inverted range falls back
                3: begin lo = 6'd0;  hi = 7'd127; end  // clamped to the store size
                4: begin lo = 6'd0;  hi = 7'd0;   end
                5: begin lo = 6'd0;  hi = 7'd1;   end
                default: begin
                    lo = 6'($urandom_range(63));
                    hi = 7'($urandom_range(127));
                end
            endcase
            write_reg(CFG_MIN_BIN, CFG_DATA_W'(lo));
            write_reg(CFG_MAX_BIN, hi);
            if (seg == 0)
                write_reg(CFG_UNUSED, '1);
            // swap the idling sides, then drop idling and stage the long hold-off
            if (seg == 3) begin
                tx_idle_pct <= 73;
                rx_idle_pct <= 24;
            end
            if (seg == 6) begin
                tx_idle_pct <= 0;
                rx_idle_pct <= 0;
                hold_go     <= 1'b1;
            end
            queued_bins = 0;
            while (queued_bins < SEG_BINS)
                queue_frame();
        end

        wait_drained();
        if (errors == 0 && onset_expect_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/cdov_pkg.sv
hw/rtl/cdov_hist.sv
hw/rtl/cdov_dev.sv
hw/rtl/cdov_alu.sv
hw/rtl/complex_domain_onset_value.sv
tb/sv/complex_domain_onset_value_test.sv
